### hw/rtl/cnms_pkg.sv
// ----------------------------------------------------------------------------
// cnms_pkg
// shared types, codes and defaults of the canny non-maximum suppression unit
// ----------------------------------------------------------------------------
`default_nettype none

package cnms_pkg;

    localparam int MAX_WIDTH_DEF       = 2048;
    localparam int GRAD_BITS_DEF       = 16;
    localparam int RATIO_FRAC_BITS_DEF = 12;

    localparam int MAG_BITS  = 16;
    localparam int ROW_BITS  = 12;
    localparam int COL_BITS  = 11;
    localparam int CFG_BITS  = 16;
    localparam int CFGW_BITS = 12;
    localparam int OUT_BITS  = 32;

    localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_LOW_LEVEL   = 2'd1;
    localparam logic [1:0] CFG_HIGH_LEVEL  = 2'd2;

    localparam logic [CFGW_BITS-1:0] RST_IMAGE_WIDTH = 12'd640;
    localparam logic [MAG_BITS-1:0]  RST_LOW_LEVEL   = 16'd6554;
    localparam logic [MAG_BITS-1:0]  RST_HIGH_LEVEL  = 16'd16384;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_DRAIN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic div_step;
        logic mul_step;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic produce;
        logic div_done;
        logic mul_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### hw/rtl/cnms_ctrl.sv
// ----------------------------------------------------------------------------
// cnms_ctrl
// sequencer: accept, line store update, ratio division, product steps, drain, result
// ----------------------------------------------------------------------------
`default_nettype none

module cnms_ctrl
    import cnms_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_in_ready
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_LOAD;
            ST_LOAD:  n_state = i_sts.produce ? ST_DIV : ST_IDLE;
            ST_DIV:   if (i_sts.div_done) n_state = ST_MUL;
            ST_MUL:   if (i_sts.mul_done) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_FIN;
            ST_FIN:   if (i_sts.out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_LOAD:  o_cmd.load     = 1'b1;
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_MUL:   o_cmd.mul_step = 1'b1;
            ST_DRAIN: o_cmd          = '0;
            ST_FIN:   o_cmd.fin      = i_sts.out_free;
            default:  o_cmd          = '0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/cnms_datapath.sv
// ----------------------------------------------------------------------------
// cnms_datapath
// counters, line stores, window, dividers, shared multiplier and result register
// ----------------------------------------------------------------------------
`default_nettype none

module cnms_datapath
    import cnms_pkg::*;
#(
    parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
    parameter int GRAD_BITS       = GRAD_BITS_DEF,
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
    localparam int WB = $clog2(MAX_WIDTH + 1),
    localparam int AW = $clog2(MAX_WIDTH)
)(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cmd                        i_cmd,
    output t_sts                             o_sts,
    input  wire logic [WB-1:0]               i_eff_width,
    input  wire logic [MAG_BITS-1:0]         i_low,
    input  wire logic [MAG_BITS-1:0]         i_high,
    input  wire logic signed [GRAD_BITS-1:0] i_gx,
    input  wire logic signed [GRAD_BITS-1:0] i_gy,
    input  wire logic [MAG_BITS-1:0]         i_mag,
    input  wire logic                        i_frame_start,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_weak,
    output logic                             o_strong,
    output logic [ROW_BITS-1:0]              o_row,
    output logic [COL_BITS-1:0]              o_col
);

    localparam int F  = RATIO_FRAC_BITS;
    localparam int GB = GRAD_BITS;
    localparam int LW = GB + 1;
    localparam int CW = $clog2(F);
    localparam int PW = F + 19;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    // counters and captured pixel
    logic [WB-1:0]       r_colcnt;
    logic [ROW_BITS-1:0] r_rowcnt;
    logic [AW-1:0]       r_c;
    logic [ROW_BITS-1:0] r_r;
    logic [MAG_BITS-1:0] r_mag;
    logic [2*GB-1:0]     r_gin;

    logic [WB-1:0]       base_c, c_now, c_next;
    logic [ROW_BITS-1:0] base_r, r_now;

    always_comb begin
        base_c = i_frame_start ? '0 : r_colcnt;
        base_r = i_frame_start ? '0 : r_rowcnt;
        if (base_c >= i_eff_width) begin
            c_now = '0;
            r_now = base_r + 1'b1;
        end else begin
            c_now = base_c;
            r_now = base_r;
        end
        c_next = c_now + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colcnt <= '0;
            r_rowcnt <= '0;
        end else if (i_cmd.accept) begin
            if (c_next >= i_eff_width) begin
                r_colcnt <= '0;
                r_rowcnt <= r_now + 1'b1;
            end else begin
                r_colcnt <= c_next;
                r_rowcnt <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c   <= c_now[AW-1:0];
            r_r   <= r_now;
            r_mag <= i_mag;
            r_gin <= {i_gy, i_gx};
        end
    end

    // line stores
    logic [2*MAG_BITS-1:0] mag_mem  [MAX_WIDTH];
    logic [2*GB-1:0]       grad_mem [MAX_WIDTH];
    logic [2*MAG_BITS-1:0] r_mrd;
    logic [2*GB-1:0]       r_grd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mrd <= mag_mem[c_now[AW-1:0]];
            r_grd <= grad_mem[c_now[AW-1:0]];
        end
        if (i_cmd.load) begin
            mag_mem[r_c]  <= {r_mrd[MAG_BITS-1:0], r_mag};
            grad_mem[r_c] <= r_gin;
        end
    end

    // window and centre gradient delay
    logic [MAG_BITS-1:0] r_win [3][3];
    logic [2*GB-1:0]     r_dly0, r_dly1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
            r_dly0 <= '0;
            r_dly1 <= '0;
        end else if (i_cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_mrd[2*MAG_BITS-1:MAG_BITS];
            r_win[1][2] <= r_mrd[MAG_BITS-1:0];
            r_win[2][2] <= r_mag;
            r_dly1      <= r_dly0;
            r_dly0      <= r_grd;
        end
    end

    // sector tests on the gradient that becomes the centre
    logic signed [LW-1:0] gx, gy, ngy;
    logic [LW-1:0]        ax, ay;
    logic [3:0]           match;

    always_comb begin
        gx  = LW'(signed'(r_dly0[GB-1:0]));
        gy  = LW'(signed'(r_dly0[2*GB-1:GB]));
        ngy = -gy;
        ax  = (gx < 0) ? LW'(-gx) : LW'(gx);
        ay  = (gy < 0) ? LW'(-gy) : LW'(gy);
        match[0] = (gy <= 0 && gx > ngy) || (gy >= 0 && gx < ngy);
        match[1] = (gx > 0 && ngy >= gx) || (gx < 0 && ngy <= gx);
        match[2] = (gx <= 0 && gx > gy) || (gx >= 0 && gx < gy);
        match[3] = (gy < 0 && gx <= gy) || (gy > 0 && gx >= gy);
    end

    // two restoring dividers: a = |gy|/|gx|, b = |gx|/|gy|
    logic [3:0]    r_match;
    logic          r_zx, r_zy, r_sat_a, r_sat_b;
    logic [LW-1:0] r_rem_a, r_rem_b, r_l_a, r_l_b;
    logic [F-1:0]  r_q_a, r_q_b;
    logic [CW-1:0] r_dcnt;
    logic [LW:0]   rem2_a, rem2_b;

    assign rem2_a = {r_rem_a, 1'b0};
    assign rem2_b = {r_rem_b, 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_match <= match;
            r_zx    <= (ax == '0);
            r_zy    <= (ay == '0);
            r_sat_a <= (ay >= ax);
            r_sat_b <= (ax >= ay);
            r_rem_a <= ay;
            r_rem_b <= ax;
            r_l_a   <= ax;
            r_l_b   <= ay;
            r_q_a   <= '0;
            r_q_b   <= '0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (rem2_a >= {1'b0, r_l_a}) begin
                r_rem_a <= LW'(rem2_a - {1'b0, r_l_a});
                r_q_a   <= {r_q_a[F-2:0], 1'b1};
            end else begin
                r_rem_a <= rem2_a[LW-1:0];
                r_q_a   <= {r_q_a[F-2:0], 1'b0};
            end
            if (rem2_b >= {1'b0, r_l_b}) begin
                r_rem_b <= LW'(rem2_b - {1'b0, r_l_b});
                r_q_b   <= {r_q_b[F-2:0], 1'b1};
            end else begin
                r_rem_b <= rem2_b[LW-1:0];
                r_q_b   <= {r_q_b[F-2:0], 1'b0};
            end
        end
    end

    logic [F:0] d_a, d_b;
    assign d_a = r_sat_a ? ONE : {1'b0, r_q_a};
    assign d_b = r_sat_b ? ONE : {1'b0, r_q_b};

    // shared multiplier: test m*2^F >= a*(2^F-d) + b*d as (m-a)*2^F >= (b-a)*d
    logic [2:0]          r_k;
    logic [MAG_BITS-1:0] sel_a, sel_b;
    logic [F:0]          sel_d;
    logic signed [MAG_BITS:0]   diff, mma;
    logic signed [PW-1:0]       prod, lhs;
    logic signed [PW-1:0]       r_prod, r_lhs;
    logic [1:0]          r_tag;
    logic                r_pv;
    logic [3:0]          r_ok;

    always_comb begin
        unique case (r_k)
            3'd0: begin sel_a = r_win[1][2]; sel_b = r_win[0][2]; sel_d = d_a; end
            3'd1: begin sel_a = r_win[1][0]; sel_b = r_win[2][0]; sel_d = d_a; end
            3'd2: begin sel_a = r_win[0][1]; sel_b = r_win[0][2]; sel_d = d_b; end
            3'd3: begin sel_a = r_win[2][1]; sel_b = r_win[2][0]; sel_d = d_b; end
            3'd4: begin sel_a = r_win[0][1]; sel_b = r_win[0][0]; sel_d = d_b; end
            3'd5: begin sel_a = r_win[2][1]; sel_b = r_win[2][2]; sel_d = d_b; end
            3'd6: begin sel_a = r_win[1][0]; sel_b = r_win[0][0]; sel_d = d_a; end
            default: begin sel_a = r_win[1][2]; sel_b = r_win[2][2]; sel_d = d_a; end
        endcase
        diff = signed'({1'b0, sel_b}) - signed'({1'b0, sel_a});
        mma  = signed'({1'b0, r_win[1][1]}) - signed'({1'b0, sel_a});
        prod = PW'(diff * signed'({1'b0, sel_d}));
        lhs  = PW'(mma) <<< F;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_k  <= '0;
            r_pv <= 1'b0;
            r_ok <= '1;
        end else begin
            r_pv <= i_cmd.mul_step;
            if (i_cmd.mul_step) begin
                r_k    <= r_k + 1'b1;
                r_prod <= prod;
                r_lhs  <= lhs;
                r_tag  <= r_k[2:1];
            end
            if (r_pv && (r_lhs < r_prod)) begin
                r_ok[r_tag] <= 1'b0;
            end
        end
    end

    // result register
    logic        lm, is_weak;
    logic [31:0] col32;
    logic [3:0]  nz;

    always_comb begin
        nz      = {~r_zx, ~r_zy, ~r_zy, ~r_zx};
        lm      = |(r_match & r_ok & nz);
        is_weak = lm && (r_win[1][1] > i_low);
        col32   = 32'(r_c) - 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_weak   <= is_weak;
            o_strong <= is_weak && (r_win[1][1] > i_high);
            o_row    <= r_r - 1'b1;
            o_col    <= col32[COL_BITS-1:0];
        end
    end

    always_comb begin
        o_sts.produce  = (r_r >= ROW_BITS'(2)) && (32'(r_c) >= 32'd2);
        o_sts.div_done = (r_dcnt == CW'(F - 1));
        o_sts.mul_done = (r_k == 3'd7);
        o_sts.out_free = !o_valid || i_ready;
    end

endmodule

`default_nettype wire

### hw/rtl/canny_nonmax_suppress_unit.sv
// ----------------------------------------------------------------------------
// canny_nonmax_suppress_unit
// interpolated non-maximum suppression with weak and strong levels on a raster
// stream of gradient pixels
// ----------------------------------------------------------------------------
//
//  channel   direction  request moved                      handshake
//  s_axis    in         grad_x, grad_y, magnitude / start  s_axis_tvalid/tready
//  m_axis    out        weak, strong, centre row and col   m_axis_tvalid/tready
//  cfg       in         register index and write data      i_cfg_valid/o_cfg_ready
//
//  a border pixel takes the accept and line store update steps; an interior
//  centre also passes ratio division by the bit-a-cycle dividers, 8 products
//  on the one shared multiplier, a drain step and the result step
//  synchronous active-low reset clears counters, window, delay and control;
//  the line stores hold garbage until the first rows have passed
//  a stalled result waits in the output register; a following border pixel
//  is still taken, an interior one holds at its last step until the slot frees
// ----------------------------------------------------------------------------
`default_nettype none

module canny_nonmax_suppress_unit
    import cnms_pkg::*;
#(
    parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
    parameter int GRAD_BITS       = GRAD_BITS_DEF,
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
    localparam int IW = ((2 * GRAD_BITS + MAG_BITS + 7) / 8) * 8
)(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // grad_x, grad_y, magnitude
    input  wire logic [IW-1:0]       s_axis_tdata,
    // frame_start
    input  wire logic                s_axis_tuser,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // weak_edge, strong_edge, center_row, center_col, zero fill
    output logic [OUT_BITS-1:0]      m_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [CFG_BITS-1:0] i_cfg_data
);

    localparam int WB = $clog2(MAX_WIDTH + 1);

    // configuration registers, taken while idle and no pixel is on offer
    logic [CFGW_BITS-1:0] r_width;
    logic [MAG_BITS-1:0]  r_low, r_high;

    assign o_cfg_ready = s_axis_tready && !s_axis_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= RST_IMAGE_WIDTH;
            r_low   <= RST_LOW_LEVEL;
            r_high  <= RST_HIGH_LEVEL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: r_width <= i_cfg_data[CFGW_BITS-1:0];
                CFG_LOW_LEVEL:   r_low   <= i_cfg_data;
                CFG_HIGH_LEVEL:  r_high  <= i_cfg_data;
                default:         r_width <= r_width;
            endcase
        end
    end

    // width clamped into 3 .. MAX_WIDTH
    logic [WB-1:0] eff_width;

    always_comb begin
        if (r_width < CFGW_BITS'(3)) begin
            eff_width = WB'(3);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            eff_width = WB'(MAX_WIDTH);
        end else begin
            eff_width = WB'(r_width);
        end
    end

    t_cmd cmd;
    t_sts sts;

    cnms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready)
    );

    logic                res_weak, res_strong;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;

    cnms_datapath #(
        .MAX_WIDTH       (MAX_WIDTH),
        .GRAD_BITS       (GRAD_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_eff_width   (eff_width),
        .i_low         (r_low),
        .i_high        (r_high),
        .i_gx          (s_axis_tdata[GRAD_BITS-1:0]),
        .i_gy          (s_axis_tdata[2*GRAD_BITS-1:GRAD_BITS]),
        .i_mag         (s_axis_tdata[2*GRAD_BITS+MAG_BITS-1:2*GRAD_BITS]),
        .i_frame_start (s_axis_tuser),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_weak        (res_weak),
        .o_strong      (res_strong),
        .o_row         (row),
        .o_col         (col)
    );

    // result fields packed from bit 0 up
    assign m_axis_tdata = {{(OUT_BITS - 2 - ROW_BITS - COL_BITS){1'b0}}, col, row,
                           res_strong, res_weak};

endmodule

`default_nettype wire

### hw/rtl/cnms_checker.sv
// ----------------------------------------------------------------------------
// cnms_checker
// port-level checks of the canny non-maximum suppression unit
// ----------------------------------------------------------------------------
`default_nettype none

module cnms_checker
    import cnms_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic [OUT_BITS-1:0] m_axis_tdata,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // strong only ever with weak
    a_strong: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("strong edge without weak edge");

    // a centre is never on row or column zero
    a_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[13:2] != 12'd0 && m_axis_tdata[24:14] != 11'd0)
        else $error("result on a border pixel");

    // one pixel at a time: input closes after each accept
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second pixel taken while the first is in work");

endmodule

bind canny_nonmax_suppress_unit cnms_checker u_cnms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire
